// ===== rtl/mi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared widths, controller states and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mi_pkg;

   localparam int WIDTH = 31;
   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_REDUCE_END,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic sel_mod;
      logic reduce_done;
      logic div_start;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic r1_zero;
      logic m_zero;
   } status_type;

endpackage

// ===== rtl/mi_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse datapath
// Remainder registers, Bezout coefficient magnitudes, a restoring bit-serial
// divider with a shift-and-add product of quotient and coefficient, and the
// result registers.
// ----------------------------------------------------------------------------
module mi_datapath import mi_pkg::*; (
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [WIDTH-1:0] value,
   input  logic [WIDTH-1:0] modulus,
   output status_type       stat,
   output logic [WIDTH-1:0] inverse,
   output logic             no_inverse
);

   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] r0_ff, r0_in;
   logic [WIDTH-1:0] r1_ff, r1_in;
   logic [WIDTH-1:0] u0_ff, u0_in;
   logic [WIDTH-1:0] u1_ff, u1_in;
   logic             neg0_ff, neg0_in;
   logic             neg1_ff, neg1_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic             noinv_ff, noinv_in;

   logic [WIDTH-1:0] divisor;
   logic [WIDTH:0]   rem_sh;
   logic             qbit;
   logic [WIDTH-1:0] rem_sub;
   logic [WIDTH-1:0] u0_red;
   logic [WIDTH-1:0] inv_mag;
   logic             bad;

   always_comb begin
      divisor = cmd.sel_mod ? m_ff : r1_ff;
      rem_sh  = {rem_ff, dvd_ff[WIDTH-1]};
      qbit    = rem_sh >= {1'b0, divisor};
      rem_sub = rem_sh[WIDTH-1:0] - divisor;
      u0_red  = (u0_ff >= m_ff) ? u0_ff - m_ff : u0_ff;
      inv_mag = (neg0_ff && (u0_red != '0)) ? m_ff - u0_red : u0_red;
      bad     = (m_ff == '0) || (r0_ff != WIDTH'(1));
   end

   always_comb begin
      m_in     = m_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      u0_in    = u0_ff;
      u1_in    = u1_ff;
      neg0_in  = neg0_ff;
      neg1_in  = neg1_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      inv_in   = inv_ff;
      noinv_in = noinv_ff;
      if (cmd.load) begin
         m_in    = modulus;
         r0_in   = modulus;
         u0_in   = '0;
         u1_in   = WIDTH'(1);
         neg0_in = 1'b0;
         neg1_in = 1'b0;
         rem_in  = '0;
         dvd_in  = value;
         acc_in  = '0;
         cnt_in  = '0;
      end
      if (cmd.div_start) begin
         rem_in = '0;
         dvd_in = r0_ff;
         acc_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = qbit ? rem_sub : rem_sh[WIDTH-1:0];
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (qbit ? u1_ff : '0);
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.reduce_done) begin
         r1_in = rem_ff;
      end
      if (cmd.update) begin
         r0_in   = r1_ff;
         r1_in   = rem_ff;
         u0_in   = u1_ff;
         u1_in   = u0_ff + acc_ff;
         neg0_in = neg1_ff;
         neg1_in = ~neg1_ff;
      end
      if (cmd.finish) begin
         noinv_in = bad;
         inv_in   = bad ? '0 : inv_mag;
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      u0_ff    <= u0_in;
      u1_ff    <= u1_in;
      neg0_ff  <= neg0_in;
      neg1_ff  <= neg1_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      inv_ff   <= inv_in;
      noinv_ff <= noinv_in;
   end

   assign stat.div_last = cnt_ff == CNT_W'(WIDTH - 1);
   assign stat.r1_zero  = r1_ff == '0;
   assign stat.m_zero   = m_ff == '0;
   assign inverse       = inv_ff;
   assign no_inverse    = noinv_ff;

`ifndef SYNTHESIS
   // The remainder handed to the next step is always below its divisor.
   a_rem_below: assert property (@(posedge clock) cmd.update |-> rem_ff < r1_ff)
      else $error("remainder not below divisor");
   // Coefficient magnitudes never exceed the modulus.
   a_coef_bound: assert property (@(posedge clock) cmd.update |=> u1_ff <= m_ff)
      else $error("coefficient exceeds modulus");
   // A flagged result carries zero, and any other result lies below the modulus.
   a_result: assert property (@(posedge clock)
      cmd.finish |=> (noinv_ff ? inv_ff == '0 : inv_ff < m_ff))
      else $error("result out of range");
`endif

endmodule

// ===== rtl/mi_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse controller
// Sequences the reduction, the Euclid steps and the result hand-off, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module mi_control import mi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (stat.div_last) state_in = ST_REDUCE_END;
         end
         ST_REDUCE_END: begin
            state_in = stat.m_zero ? ST_FINISH : ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.r1_zero ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (stat.div_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_REDUCE: begin
            cmd.div_step = 1'b1;
            cmd.sel_mod  = 1'b1;
         end
         ST_REDUCE_END: begin
            cmd.reduce_done = 1'b1;
         end
         ST_CHECK: begin
            cmd.div_start = !stat.r1_zero;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An accepted beat always starts with the reduction of the value.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_REDUCE)
      else $error("accepted beat did not start reduction");
   // A finished result is presented on the next cycle.
   a_present: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");
   // The last division step is always followed by the coefficient update.
   a_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && stat.div_last) |=> state_ff == ST_UPDATE)
      else $error("division did not end in update");
`endif

endmodule

// ===== rtl/modular_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse
// Returns the inverse of a value modulo a modulus by the extended Euclidean
// algorithm, or flags that no inverse exists.
//
// The request channel carries a value and a modulus; the response channel
// returns one beat per request with the inverse and a no-inverse flag. When
// the gcd of value and modulus is not 1, or the modulus is 0, the flag is set
// and the inverse is 0. A modulus of 1 gives an inverse of 0.
// One request is worked at a time. The value is first reduced by the modulus;
// each Euclid step then runs the restoring divider, which produces one
// quotient bit per cycle, and updates the coefficients. Operands are 31 bits
// wide. A new request is taken once the result has moved into the output
// register, even while it still waits.
// Reset is synchronous and returns the block to idle with no result pending.
// While the receiver stalls, the result beat holds and a following request
// completes its work but waits before its result is written.
// ----------------------------------------------------------------------------
module modular_inverse import mi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_value,
   input  logic [WIDTH-1:0] req_modulus,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic             rsp_no_inverse
);

   cmd_type    cmd;
   status_type stat;

   mi_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mi_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .value      (req_value),
      .modulus    (req_modulus),
      .stat       (stat),
      .inverse    (rsp_inverse),
      .no_inverse (rsp_no_inverse)
   );

endmodule

// ===== verif/modular_inverse_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse checker
// Watches the request and response channels of the modular inverse block.
// Each accepted request beat is run through an extended Euclidean model and
// its expected result is queued. Each accepted response beat is compared
// field by field with the oldest queued result. The number of failures and
// the number of results still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module modular_inverse_check import mi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [WIDTH-1:0] req_value,
   input  logic [WIDTH-1:0] req_modulus,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [WIDTH-1:0] rsp_inverse,
   input  logic             rsp_no_inverse,
   output int               error_count,
   output int               pending
);

   typedef struct packed {
      logic [WIDTH-1:0] inverse;
      logic             no_inverse;
   } inverse_beat_type;

   inverse_beat_type expected_inverses[$];

   initial begin
      error_count = 0;
      pending = 0;
   end

   // Coefficient magnitudes stay within the modulus, and their signs alternate
   // from one step to the next, so only magnitudes and a sign flag for each are kept.
   function automatic inverse_beat_type predict_inverse(logic [WIDTH-1:0] value,
                                                        logic [WIDTH-1:0] modulus);
      inverse_beat_type beat;
      logic [63:0] rem_prev, rem_cur, coef_prev, coef_cur, quot, tmp, mod_wide;
      bit neg_prev, neg_cur;
      beat.inverse = '0;
      beat.no_inverse = 1'b1;
      mod_wide = 64'(modulus);
      if (mod_wide == 0) begin
         return beat;
      end
      rem_prev = mod_wide;
      rem_cur = 64'(value) % mod_wide;
      coef_prev = 0;
      coef_cur = 1;
      neg_prev = 1'b0;
      neg_cur = 1'b0;
      while (rem_cur != 0) begin
         quot = rem_prev / rem_cur;
         tmp = rem_prev - quot * rem_cur;
         rem_prev = rem_cur;
         rem_cur = tmp;
         tmp = coef_prev + quot * coef_cur;
         coef_prev = coef_cur;
         coef_cur = tmp;
         neg_prev = neg_cur;
         neg_cur = !neg_cur;
      end
      if (rem_prev != 1) begin
         return beat;
      end
      coef_prev = coef_prev % mod_wide;
      if (neg_prev && coef_prev != 0) begin
         coef_prev = mod_wide - coef_prev;
      end
      beat.inverse = coef_prev[WIDTH-1:0];
      beat.no_inverse = 1'b0;
      return beat;
   endfunction

   always @(posedge clock) begin : watch
      inverse_beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_inverses.push_back(predict_inverse(req_value, req_modulus));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_inverses.size() == 0) begin
               $error("unexpected result beat: inverse %0d, no_inverse %0d",
                      rsp_inverse, rsp_no_inverse);
               error_count++;
            end else begin
               want = expected_inverses.pop_front();
               if (rsp_inverse !== want.inverse) begin
                  $error("inverse: expected %0d, actual %0d", want.inverse, rsp_inverse);
                  error_count++;
               end
               if (rsp_no_inverse !== want.no_inverse) begin
                  $error("no_inverse: expected %0d, actual %0d",
                         want.no_inverse, rsp_no_inverse);
                  error_count++;
               end
            end
         end
      end
      pending = expected_inverses.size();
   end

endmodule

// ===== verif/modular_inverse_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse testbench
// Drives the modular inverse block with a directed set of corner cases and
// then with random value and modulus pairs over four phases with differing
// rates of idling and stalling. A checker beside the block predicts and compares every result
// beat; this top makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module modular_inverse_test import mi_pkg::*; ();

   localparam int          LIMIT = 3_000_000;
   localparam int          DRAIN = 200;
   localparam int          PHASE_BEATS = 100;
   localparam int unsigned MAX_FIELD = (32'd1 << WIDTH) - 1;
   localparam int unsigned FIB_LOW = 1134903170;
   localparam int unsigned FIB_HIGH = 1836311903;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [WIDTH-1:0] req_value = '0;
   logic [WIDTH-1:0] req_modulus = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [WIDTH-1:0] rsp_inverse;
   logic             rsp_no_inverse;

   int error_count;
   int pending;
   int cycle_count = 0;
   int send_idle = 0;
   int recv_stall = 0;

   modular_inverse i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_modulus    (req_modulus),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inverse    (rsp_inverse),
      .rsp_no_inverse (rsp_no_inverse)
   );

   modular_inverse_check i_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_modulus    (req_modulus),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inverse    (rsp_inverse),
      .rsp_no_inverse (rsp_no_inverse),
      .error_count    (error_count),
      .pending        (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_pair(input int unsigned value, input int unsigned modulus);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= WIDTH'(value);
      req_modulus <= WIDTH'(modulus);
      do @(posedge clock); while (req_stall);
   endtask

   initial begin : stimulus
      int unsigned value, modulus, factor;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(0, 1);
      send_pair(MAX_FIELD, 1);
      send_pair(0, 12);
      send_pair(0, MAX_FIELD);
      send_pair(3, 7);
      send_pair(10, 7);
      send_pair(1, MAX_FIELD);
      send_pair(2, MAX_FIELD);
      send_pair(MAX_FIELD - 1, MAX_FIELD);
      send_pair(MAX_FIELD, MAX_FIELD);
      send_pair(MAX_FIELD, 2);
      send_pair(6, 9);
      send_pair(FIB_LOW, FIB_HIGH);
      send_pair(FIB_HIGH, FIB_LOW);
      send_pair(32'h2AAA_AAAA, 32'h5555_5555);
      send_pair(32'h5555_5555, 32'h2AAA_AAAA);
      send_pair(12345, 32'h4000_0000);
      send_pair(MAX_FIELD, 0);
      send_pair(0, 0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle = 0;
               recv_stall = 0;
            end
            1: begin
               send_idle = 70;
               recv_stall = 0;
            end
            2: begin
               send_idle = 0;
               recv_stall = 70;
            end
            default: begin
               send_idle = 17;
               recv_stall = 17;
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            value = $urandom() & MAX_FIELD;
            modulus = $urandom() & MAX_FIELD;
            case ($urandom_range(0, 9))
               0, 1: modulus = $urandom_range(1, 100);
               2, 3: begin
                  // A shared factor makes the gcd exceed one.
                  factor = $urandom_range(2, 1000);
                  value = factor * $urandom_range(0, MAX_FIELD / factor);
                  modulus = factor * $urandom_range(1, MAX_FIELD / factor);
               end
               4: modulus = MAX_FIELD;
               5: value = $urandom_range(0, 65535);
               default: begin
               end
            endcase
            if (modulus == 0) begin
               modulus = 1;
            end
            send_pair(value, modulus);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mi_pkg.sv
rtl/mi_datapath.sv
rtl/mi_control.sv
rtl/modular_inverse.sv
verif/modular_inverse_check.sv
verif/modular_inverse_test.sv
